[hdl/rab_pkg.sv]
// ----------------------------------------------------------------------------
// rab_pkg
// Shared constants, types and helpers for the range to aligned blocks core.
// ----------------------------------------------------------------------------
package rab_pkg;

	localparam int unsigned ADDR_WIDTH = 32;
	localparam int unsigned DATA_W     = 32;
	localparam logic [DATA_W-1:0] ADDR_MASK = DATA_W'((64'd1 << ADDR_WIDTH) - 64'd1);

	localparam int unsigned DESC_DEPTH = 2;
	localparam int unsigned DESC_PTR_W = (DESC_DEPTH > 1) ? $clog2(DESC_DEPTH) : 1;
	localparam int unsigned DESC_CNT_W = $clog2(DESC_DEPTH + 1);

	typedef logic [DATA_W-1:0] addr_t;

	typedef struct packed {
		logic  empty;
		addr_t base;
		addr_t span;
	} desc_t;

	// isolate the highest set bit
	function automatic addr_t top_bit(input addr_t x);
		addr_t s;
		s = x;
		for (int sh = 1; sh < DATA_W; sh = sh * 2) begin
			s = s | (s >> sh);
		end
		return s & ~(s >> 1);
	endfunction

	// isolate the lowest set bit, zero for zero
	function automatic addr_t low_bit(input addr_t x);
		return x & (~x + addr_t'(1));
	endfunction

endpackage

[hdl/range_to_aligned_blocks_core.sv]
// ----------------------------------------------------------------------------
// range_to_aligned_blocks_core
// Splits a half-open range into the fewest naturally aligned power-of-two
// blocks, emitted in ascending order with the last one marked.
// ----------------------------------------------------------------------------
//  channel  | handshake    | payload
//  ---------+--------------+-------------------------------------------------
//  input    | push / full  | range_low, range_high
//  result   | empty / pop  | block_start, block_end, is_last, empty_range
//
//  the walker emits one block per cycle while pop keeps the output register
//  free, and loads a range first when it was idle; an empty range gives one result
//  ranges of up to 62 blocks; the walker sets the rate, the input side queues
//  two ranges ahead of it
//  arst_n clears the descriptor queue, the walker and the output register
//  a stalled pop holds the output register and pauses the walker
// ----------------------------------------------------------------------------
module range_to_aligned_blocks_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic [31:0] range_low,
	input  logic [31:0] range_high,
	output logic        empty,
	input  logic        pop,
	output logic [31:0] block_start,
	output logic [31:0] block_end,
	output logic        is_last,
	output logic        empty_range
);

	logic           desc_valid;
	logic           desc_pop;
	rab_pkg::desc_t desc;

	rab_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.full       (full),
		.range_low  (range_low),
		.range_high (range_high),
		.desc_valid (desc_valid),
		.desc       (desc),
		.desc_pop   (desc_pop)
	);

	rab_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.desc_valid  (desc_valid),
		.desc        (desc),
		.desc_pop    (desc_pop),
		.empty       (empty),
		.pop         (pop),
		.block_start (block_start),
		.block_end   (block_end),
		.is_last     (is_last),
		.empty_range (empty_range)
	);

`ifndef SYNTH
	a_block_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !empty_range) |-> (block_end > block_start))
		else $error("block end not above block start");

	a_block_aligned: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !empty_range) |->
		((block_start & (block_end - block_start - 32'd1)) == 32'd0))
		else $error("block not naturally aligned");

	a_block_pow2: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !empty_range) |-> $onehot(block_end - block_start))
		else $error("block size not a power of two");

	a_empty_result: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && empty_range) |->
		(is_last && (block_start == 32'd0) && (block_end == 32'd0)))
		else $error("empty range result malformed");
`endif

endmodule

[hdl/rab_front.sv]
// ----------------------------------------------------------------------------
// rab_front
// Accepts ranges, masks and classifies them, and queues a descriptor per range.
// ----------------------------------------------------------------------------
module rab_front (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	output logic                 full,
	input  logic [31:0]          range_low,
	input  logic [31:0]          range_high,
	output logic                 desc_valid,
	output rab_pkg::desc_t       desc,
	input  logic                 desc_pop
);

	rab_pkg::addr_t lo;
	rab_pkg::addr_t hi;
	rab_pkg::desc_t wr_desc;
	rab_pkg::desc_t q_mem [rab_pkg::DESC_DEPTH];

	logic [rab_pkg::DESC_PTR_W-1:0] wr_ptr_q;
	logic [rab_pkg::DESC_PTR_W-1:0] rd_ptr_q;
	logic [rab_pkg::DESC_CNT_W-1:0] count_q;
	logic                           push_ok;
	logic                           pop_ok;

	always_comb begin
		lo            = range_low & rab_pkg::ADDR_MASK;
		hi            = range_high & rab_pkg::ADDR_MASK;
		wr_desc.empty = (lo >= hi);
		wr_desc.base  = lo;
		wr_desc.span  = hi - lo;
	end

	assign full       = (count_q == rab_pkg::DESC_CNT_W'(rab_pkg::DESC_DEPTH));
	assign desc_valid = (count_q != '0);
	assign desc       = q_mem[rd_ptr_q];
	assign push_ok    = push && !full;
	assign pop_ok     = desc_pop && desc_valid;

	always_ff @(posedge clk) begin
		if (push_ok) begin
			q_mem[wr_ptr_q] <= wr_desc;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push_ok) begin
				wr_ptr_q <= (wr_ptr_q == rab_pkg::DESC_PTR_W'(rab_pkg::DESC_DEPTH - 1)) ?
					'0 : wr_ptr_q + 1'b1;
			end
			if (pop_ok) begin
				rd_ptr_q <= (rd_ptr_q == rab_pkg::DESC_PTR_W'(rab_pkg::DESC_DEPTH - 1)) ?
					'0 : rd_ptr_q + 1'b1;
			end
			if (push_ok && !pop_ok) begin
				count_q <= count_q + 1'b1;
			end else if (pop_ok && !push_ok) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

[hdl/rab_back.sv]
// ----------------------------------------------------------------------------
// rab_back
// Walks one range at a time and emits one aligned block per cycle into an
// output register, while that register is empty or being popped.
// ----------------------------------------------------------------------------
module rab_back (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 desc_valid,
	input  rab_pkg::desc_t       desc,
	output logic                 desc_pop,
	output logic                 empty,
	input  logic                 pop,
	output logic [31:0]          block_start,
	output logic [31:0]          block_end,
	output logic                 is_last,
	output logic                 empty_range
);

	logic           busy_q;
	logic           empty_q;
	rab_pkg::addr_t cur_q;
	rab_pkg::addr_t rem_q;

	logic           out_valid_q;
	rab_pkg::addr_t start_q;
	rab_pkg::addr_t end_q;
	logic           last_q;
	logic           emp_q;

	rab_pkg::addr_t lsb;
	rab_pkg::addr_t msb;
	rab_pkg::addr_t size;
	logic           step_last;
	logic           out_adv;
	logic           emit;

	// largest block at the cursor's alignment that fits in what is left
	always_comb begin
		lsb       = rab_pkg::low_bit(cur_q);
		msb       = rab_pkg::top_bit(rem_q);
		size      = ((lsb == '0) || (msb < lsb)) ? msb : lsb;
		step_last = empty_q || (size == rem_q);
		out_adv   = !out_valid_q || pop;
		emit      = busy_q && out_adv;
		desc_pop  = desc_valid && (!busy_q || (emit && step_last));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (desc_pop) begin
				busy_q <= 1'b1;
			end else if (emit && step_last) begin
				busy_q <= 1'b0;
			end
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (desc_pop) begin
			empty_q <= desc.empty;
			cur_q   <= desc.base;
			rem_q   <= desc.span;
		end else if (emit) begin
			cur_q <= cur_q + size;
			rem_q <= rem_q - size;
		end
		if (emit) begin
			start_q <= empty_q ? '0 : cur_q;
			end_q   <= empty_q ? '0 : cur_q + size;
			last_q  <= step_last;
			emp_q   <= empty_q;
		end
	end

	assign empty       = !out_valid_q;
	assign block_start = start_q;
	assign block_end   = end_q;
	assign is_last     = last_q;
	assign empty_range = emp_q;

endmodule
